@@ src/llt_pkg.sv @@
// Package for the list line trimmer: constants, character codes and the
// command word that the front end hands to the back end through the queue.
// Depends on nothing; every other file of the block imports it.
package llt_pkg;

	// Deepest run of pending whitespace that is kept for replay.
	localparam int WS_DEPTH = 32;
	// Width of a pending count (0 .. WS_DEPTH) and of an index into the run.
	localparam int CNT_W = $clog2(WS_DEPTH + 1);
	localparam int IDX_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

	// Depth of the command queue between front and back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Character codes.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// One command: replay ws_count whitespace bytes from ws_bits (1 = tab),
	// then emit ch, or, when done is set, a single entry-closing word.
	typedef struct packed {
		logic [WS_DEPTH-1:0] ws_bits;
		logic [CNT_W-1:0]    ws_count;
		logic [7:0]          ch;
		logic                done;
		logic                ovf;
	} llt_cmd_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic valid;
		logic full;
	} llt_q_status_t;

endpackage

@@ src/list_line_trimmer.sv @@
// Top level of the list line trimmer: joins front end, command queue and back end.
// Depends on llt_pkg, llt_front, llt_queue and llt_back.
//
// Usage: raw list text enters on the slave stream one byte per word; tuser
// set marks the end of the input, and the byte is then ignored. Cleaned
// entry characters leave on the master stream one per word: tdata is the
// lower-cased character, tuser[0] marks the word that closes an entry (its
// character is then zero), tuser[1] flags a whitespace run that overflowed
// its buffer, and tlast marks the last output word caused by an input word.
// The command of an accepted input word is written into the command queue, and
// its first output word then passes through the output register. An input
// word yields at most one output word, but a content byte that follows pending
// whitespace yields the pending count plus one words (up to 33), so the output
// port sets the rate while a run is replayed. The two-entry command queue lets
// the front end keep accepting during a replay until the queue is full.
// Reset clears the scanner to the start of a line and empties the queue
// and the output register. When the receiver stalls, the output word holds,
// the queue fills and tready then falls.
module list_line_trimmer
	import llt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tuser,  // [0] stream_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_char
	output logic [1:0] m_tuser,  // [0] entry_done, [1] ws_overflow
	output logic       m_tlast   // run_last
);

	llt_q_status_t q_status;
	llt_cmd_t      push_cmd;
	llt_cmd_t      head;
	logic          push;
	logic          pop;
	logic          entry_done;
	logic          ws_overflow;

	// The front end scans bytes and decides what each word will produce.
	llt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.in_byte   (s_tdata),
		.stream_end(s_tuser),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Commands wait here so that a long replay does not stall the input at once.
	llt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	// The back end turns each command into one or more output words.
	llt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_char   (m_tdata),
		.entry_done (entry_done),
		.ws_overflow(ws_overflow),
		.run_last   (m_tlast)
	);

	assign m_tuser = {ws_overflow, entry_done};

	// A command is never pushed into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_status.full)
		else $error("command pushed into a full queue");

	// A word that closes an entry carries no character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
		else $error("entry close word carries a character");

	// Closing an entry is always the last word of its input word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("entry close word not marked last");

	// A popped command leaves the queue only while it is valid.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_status.valid)
		else $error("pop from an empty queue");

endmodule

@@ src/llt_queue.sv @@
// Short command queue between the front end and the back end of the
// list line trimmer. Depends on llt_pkg for the command type and depth.
module llt_queue
	import llt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  llt_cmd_t      push_cmd,
	input  logic          pop,
	output llt_cmd_t      head,
	output llt_q_status_t status
);

	llt_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
		logic [QPTR_W-1:0] nxt;
		if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

	assign head         = entry_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/llt_front.sv @@
// Front end of the list line trimmer: accepts input words, tracks the line
// scanner state and pending whitespace, and queues output commands. Uses llt_pkg.
module llt_front
	import llt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    in_byte,
	input  logic          stream_end,
	input  llt_q_status_t q_status,
	output logic          push,
	output llt_cmd_t      push_cmd
);

	localparam logic [1:0] ST_START   = 2'd0;
	localparam logic [1:0] ST_CONTENT = 2'd1;
	localparam logic [1:0] ST_WS      = 2'd2;
	localparam logic [1:0] ST_COMMENT = 2'd3;

	logic [1:0]          scan_q, scan_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                has_q, has_d;
	logic                ovf_q, ovf_d;
	logic [WS_DEPTH-1:0] ws_q, ws_d;
	logic                accept;

	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		scan_d            = scan_q;
		cnt_d             = cnt_q;
		has_d             = has_q;
		ovf_d             = ovf_q;
		ws_d              = ws_q;
		push              = 1'b0;
		push_cmd.ws_bits  = ws_q;
		push_cmd.ws_count = '0;
		push_cmd.ch       = '0;
		push_cmd.done     = 1'b0;
		push_cmd.ovf      = 1'b0;
		if (accept) begin
			if (stream_end) begin
				push          = has_q;
				push_cmd.done = 1'b1;
				scan_d        = ST_START;
				cnt_d         = '0;
				has_d         = 1'b0;
				ovf_d         = 1'b0;
			end else if (in_byte == CH_CR) begin
				scan_d = scan_q;
			end else if (in_byte == CH_LF) begin
				push          = 1'b1;
				push_cmd.done = 1'b1;
				scan_d        = ST_START;
				cnt_d         = '0;
				has_d         = 1'b0;
				ovf_d         = 1'b0;
			end else if (in_byte == CH_SEMI) begin
				scan_d = ST_COMMENT;
				cnt_d  = '0;
				ovf_d  = 1'b0;
			end else if (in_byte inside {CH_SPACE, CH_TAB}) begin
				if (scan_q == ST_CONTENT || scan_q == ST_WS) begin
					if (cnt_q < CNT_W'(WS_DEPTH)) begin
						ws_d[cnt_q[IDX_W-1:0]] = (in_byte == CH_TAB);
						cnt_d = cnt_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					scan_d = ST_WS;
				end
			end else if (scan_q != ST_COMMENT) begin
				push = 1'b1;
				if (in_byte inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
					push_cmd.ch = in_byte + CASE_OFFSET;
				end else begin
					push_cmd.ch = in_byte;
				end
				if (scan_q == ST_WS) begin
					push_cmd.ws_count = cnt_q;
					push_cmd.ovf      = ovf_q;
				end
				scan_d = ST_CONTENT;
				cnt_d  = '0;
				has_d  = 1'b1;
				ovf_d  = 1'b0;
			end
		end
	end

	// The whitespace run holds data only; entries at or above the count are never read.
	always_ff @(posedge clk) begin
		ws_q <= ws_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= ST_START;
			cnt_q  <= '0;
			has_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			scan_q <= scan_d;
			cnt_q  <= cnt_d;
			has_q  <= has_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

@@ src/llt_back.sv @@
// Back end of the list line trimmer: expands the queue's head command into output words,
// one per cycle unless the output stalls, into a registered output stage. Uses llt_pkg.
module llt_back
	import llt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  llt_cmd_t      head,
	input  llt_q_status_t q_status,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    out_char,
	output logic          entry_done,
	output logic          ws_overflow,
	output logic          run_last
);

	logic [CNT_W-1:0] idx_q;
	logic             advance;
	logic             emit;
	logic             last;
	logic [7:0]       char_d;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             done_q;
	logic             ovf_q;
	logic             last_q;

	assign advance = !valid_q || m_tready;
	assign emit    = advance && q_status.valid;
	assign last    = (idx_q == head.ws_count);
	assign pop     = emit && last;

	always_comb begin
		if (last) begin
			char_d = head.ch;
		end else if (head.ws_bits[idx_q[IDX_W-1:0]]) begin
			char_d = CH_TAB;
		end else begin
			char_d = CH_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= char_d;
			done_q <= head.done && last;
			ovf_q  <= head.ovf;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) begin
				valid_q <= q_status.valid;
			end
			if (emit) begin
				if (last) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign m_tvalid    = valid_q;
	assign out_char    = char_q;
	assign entry_done  = done_q;
	assign ws_overflow = ovf_q;
	assign run_last    = last_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the list line trimmer: directed, stress and random list text.
// A predictor in this file forecasts every output word, and a checker compares each one.
// Depends on llt_pkg and list_line_trimmer.
module testbench
	import llt_pkg::*;
;

	localparam int CLK_PERIOD   = 20;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef enum logic [1:0] {
		SCAN_START,
		SCAN_CONTENT,
		SCAN_WS,
		SCAN_COMMENT
	} scan_t;

	typedef struct {
		logic [7:0] ch;
		logic       done;
		logic       ovf;
		logic       last;
	} cleaned_word_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;  // [7:0] in_byte
	logic       s_tuser;  // [0] stream_end
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;  // [7:0] out_char
	logic [1:0] m_tuser;  // [0] entry_done, [1] ws_overflow
	logic       m_tlast;  // run_last

	// Predictor state.
	scan_t               line_state;
	logic [WS_DEPTH-1:0] held_ws;
	int                  held_count;
	logic                line_has_text;
	logic                held_overflow;

	cleaned_word_t cleaned_words[$];
	int            words_sent;
	int            mismatches;
	bit            tx_idle_on;
	bit            rx_idle_on;
	int            rx_hold_cycles;

	list_line_trimmer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	function automatic void push_word(logic [7:0] ch, logic done, logic ovf, logic last);
		cleaned_word_t w;
		w.ch   = ch;
		w.done = done;
		w.ovf  = ovf;
		w.last = last;
		cleaned_words.push_back(w);
	endfunction

	function automatic void clear_scanner();
		line_state    = SCAN_START;
		held_ws       = '0;
		held_count    = 0;
		line_has_text = 1'b0;
		held_overflow = 1'b0;
	endfunction

	// Works out the output words that one accepted input word causes.
	function automatic void trim_byte(logic [7:0] b, logic eos);
		logic       ovf;
		logic [7:0] c;
		if (eos) begin
			if (line_has_text)
				push_word(8'h00, 1'b1, 1'b0, 1'b1);
			clear_scanner();
		end else if (b == CH_CR) begin
			// Carriage returns vanish without trace.
		end else if (b == CH_LF) begin
			push_word(8'h00, 1'b1, 1'b0, 1'b1);
			held_count    = 0;
			held_overflow = 1'b0;
			line_has_text = 1'b0;
			line_state    = SCAN_START;
		end else if (b == CH_SEMI) begin
			held_count    = 0;
			held_overflow = 1'b0;
			line_state    = SCAN_COMMENT;
		end else if (b == CH_SPACE || b == CH_TAB) begin
			if (line_state == SCAN_CONTENT || line_state == SCAN_WS) begin
				if (held_count < WS_DEPTH) begin
					held_ws[held_count] = (b == CH_TAB);
					held_count++;
				end else begin
					held_overflow = 1'b1;
				end
				line_state = SCAN_WS;
			end
		end else if (line_state != SCAN_COMMENT) begin
			// Held whitespace is replayed ahead of the content byte, all flagged alike.
			ovf = (line_state == SCAN_WS) && held_overflow;
			if (line_state == SCAN_WS)
				for (int i = 0; i < held_count; i++)
					push_word(held_ws[i] ? CH_TAB : CH_SPACE, 1'b0, ovf, 1'b0);
			c = b;
			if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
				c = c + CASE_OFFSET;
			push_word(c, 1'b0, ovf, 1'b1);
			held_count    = 0;
			held_overflow = 1'b0;
			line_has_text = 1'b1;
			line_state    = SCAN_CONTENT;
		end
	endfunction

	// Offers one word, possibly after a random idle burst, and waits for the handshake.
	task automatic send_word(input logic [7:0] b, input logic eos);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		trim_byte(b, eos);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	task automatic send_ws_run(input int n);
		repeat (n)
			send_word(($urandom_range(0, 1) == 1) ? CH_TAB : CH_SPACE, 1'b0);
	endtask

	function automatic logic [7:0] pick_text_byte();
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 9);
		if (r < 4)
			b = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
		else if (r < 7)
			b = 8'($urandom_range(8'h61, 8'h7A));
		else if (r < 9)
			b = 8'($urandom_range(8'h21, 8'h7E));
		else
			b = 8'($urandom_range(8'h80, 8'hFF));
		if (b == CH_SEMI)
			b = 8'h5F;
		return b;
	endfunction

	// Mostly well-formed list lines with random content; some noise bytes instead.
	task automatic send_list_line();
		int words;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
		end else begin
			if ($urandom_range(0, 2) == 0)
				send_ws_run($urandom_range(1, 3));
			words = $urandom_range(0, 4);
			for (int w = 0; w < words; w++) begin
				if (w > 0)
					send_ws_run(($urandom_range(0, 19) == 0) ? $urandom_range(28, 40)
						: $urandom_range(1, 3));
				repeat ($urandom_range(1, 6))
					send_word(pick_text_byte(), 1'b0);
			end
			if ($urandom_range(0, 2) == 0)
				send_ws_run($urandom_range(1, 4));
			if ($urandom_range(0, 3) == 0) begin
				send_word(CH_SEMI, 1'b0);
				repeat ($urandom_range(0, 5))
					if ($urandom_range(0, 3) == 0)
						send_ws_run(1);
					else
						send_word(pick_text_byte(), 1'b0);
			end
			if ($urandom_range(0, 3) == 0)
				send_word(CH_CR, 1'b0);
			if ($urandom_range(0, 14) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b1);
			else
				send_word(CH_LF, 1'b0);
		end
	endtask

	// Stops offering words and waits until every forecast word has come out.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cleaned_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Extremes of the byte, every kind of byte, comments, empty entries and stream end.
	task automatic test_directed_bytes();
		send_word(CH_SPACE, 1'b0);
		send_word(CH_TAB, 1'b0);
		send_text("AZ@[");
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_text(" \tq\r \n\n;x \nk ;y\nm");
		send_word(8'hA5, 1'b1);
		send_word(8'h00, 1'b1);
	endtask

	// A full run of held whitespace, runs beyond the depth, and a discarded overflow.
	task automatic test_whitespace_depth();
		send_text("a");
		send_ws_run(WS_DEPTH);
		send_text("b");
		send_text("c");
		send_ws_run(WS_DEPTH + 3);
		send_text("D");
		send_ws_run(WS_DEPTH + 2);
		send_word(CH_LF, 1'b0);
		send_text("f g\n");
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_output_stall();
		rx_hold_cycles = 300;
		repeat (4) send_list_line();
	endtask

	// The sender stops until the block has emptied, then resumes.
	task automatic test_drain_pause();
		repeat (3) send_list_line();
		wait_drained();
		repeat (3) send_list_line();
		wait_drained();
	endtask

	task automatic test_random_lines(input int count);
		int start;
		start = words_sent;
		while (words_sent - start < count)
			send_list_line();
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_cycles - 1) @(negedge clk);
				rx_hold_cycles = 0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_words
		cleaned_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cleaned_words.size() == 0) begin
				$display("%0t: unexpected word ch=%h done=%b ovf=%b last=%b", $time,
					m_tdata, m_tuser[0], m_tuser[1], m_tlast);
				mismatches++;
			end else begin
				want = cleaned_words.pop_front();
				if (m_tdata !== want.ch || m_tuser[0] !== want.done ||
				    m_tuser[1] !== want.ovf || m_tlast !== want.last) begin
					$display("%0t: expected ch=%h done=%b ovf=%b last=%b, got ch=%h done=%b ovf=%b last=%b",
						$time, want.ch, want.done, want.ovf, want.last,
						m_tdata, m_tuser[0], m_tuser[1], m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tuser        = 1'b0;
		words_sent     = 0;
		mismatches     = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		rx_hold_cycles = 0;
		clear_scanner();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_bytes();
		wait_drained();
		test_whitespace_depth();
		test_output_stall();
		test_drain_pause();
		test_random_lines(130);
		// The closing stretch runs at full rate on both sides.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_lines(60);
		wait_drained();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
src/llt_pkg.sv
src/llt_queue.sv
src/llt_front.sv
src/llt_back.sv
src/list_line_trimmer.sv
tb/testbench.sv
